/* sv/max_free_gap_window_defines.svh */
// ----------------------------------------------------------------------------
// max_free_gap_window_defines
// assertion macros for the free gap window top file; they expect clk and
// rst_n to be visible in the scope where they are used
// ----------------------------------------------------------------------------
`ifndef MAX_FREE_GAP_WINDOW_DEFINES_SVH
`define MAX_FREE_GAP_WINDOW_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MFGW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfgw same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MFGW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfgw next-cycle check failed");

`endif

/* sv/mfgw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgw_pkg
// types and constants shared by the free gap window modules
// ----------------------------------------------------------------------------
package mfgw_pkg;

    localparam int STAMP_W   = 32;
    localparam int MOVES_W   = 6;
    localparam int CFG_IDX_W = 1;

    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [MOVES_W-1:0]   moves_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t CFG_EVENT_END     = 1'b0;
    localparam cfg_idx_t CFG_MOVES_ALLOWED = 1'b1;

    // word handed from the front stage to the window stage
    typedef struct packed {
        logic   last;
        stamp_t gap_first;
        stamp_t gap_final;
    } front_word_t;

endpackage

/* sv/mfgw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgw_front
// input register stage: turns a meeting into its leading gap and, for the
// last meeting, the closing gap up to the event end
// ----------------------------------------------------------------------------
module mfgw_front
    import mfgw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  stamp_t      meeting_start,
    input  stamp_t      meeting_end,
    input  logic        last_meeting,
    input  stamp_t      event_end,
    input  logic        take,
    output logic        word_valid,
    output front_word_t word
);

    logic        valid_reg;
    logic        first_reg;
    stamp_t      prev_end_reg;
    front_word_t word_reg;
    front_word_t word_next;
    logic        accept;

    // hold the input while the window stage keeps the current word
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    // gap math, negative gaps clamp to zero
    always_comb
    begin
        word_next.last = last_meeting;
        if (first_reg)
        begin
            word_next.gap_first = meeting_start;
        end
        else
        begin
            word_next.gap_first = (meeting_start >= prev_end_reg)
                                ? meeting_start - prev_end_reg : '0;
        end
        word_next.gap_final = (event_end >= meeting_end) ? event_end - meeting_end : '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            first_reg    <= 1'b1;
            prev_end_reg <= '0;
        end
        else if (accept)
        begin
            valid_reg    <= 1'b1;
            first_reg    <= last_meeting;
            prev_end_reg <= meeting_end;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

/* sv/mfgw_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfgw_cell
// one cell of the gap shift line: holds one past gap, hands it to the next
// cell on every push and offers it as the leaving gap when it is the tap
// ----------------------------------------------------------------------------
module mfgw_cell
    import mfgw_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             push,
    input  stamp_t           data_in,
    input  logic [IDX_W-1:0] tap_idx,
    output stamp_t           data_out,
    output stamp_t           tap_out
);

    stamp_t gap_reg;

    // shift on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            gap_reg <= data_in;
        end
    end

    assign data_out = gap_reg;

    // masked tap, or-combined across the row
    assign tap_out = (tap_idx == IDX_W'(INDEX)) ? gap_reg : '0;

endmodule

/* sv/max_free_gap_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_free_gap_window
// largest sum of moves_allowed + 1 consecutive free gaps in a meeting stream
// ----------------------------------------------------------------------------
// Takes one meeting word per cycle while in_stall is low. A meeting that is
// not the last of its stream takes a single push; the last takes two, since
// its leading gap and its closing gap (up to event_end) both pass through the
// single sum-and-compare unit, one gap per push. The result word is registered
// after the closing gap and waits in an output register; meetings that are not
// last keep flowing while it is stalled, but a further last meeting waits. Past
// gaps live in a row of MAX_WINDOW cells that shift on every gap; the gap leaving
// the window is tapped at cell moves_allowed. There is no clearing pass after
// reset. Write configuration only between items.
`include "max_free_gap_window_defines.svh"

module max_free_gap_window
    import mfgw_pkg::*;
#(
    parameter int MAX_WINDOW = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STAMP_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [STAMP_W-1:0]   meeting_start,
    input  logic [STAMP_W-1:0]   meeting_end,
    input  logic                 last_meeting,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STAMP_W-1:0]   best_free_time
);

    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int SEEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (IDX_W > MOVES_W) ? IDX_W : MOVES_W;

    stamp_t            event_end_reg;
    moves_t            moves_reg;
    logic              word_valid;
    front_word_t       word;
    logic              take;
    logic              phase_reg;
    logic              out_free;
    logic              push;
    logic              emit;
    stamp_t            gap_sel;
    logic [CMP_W-1:0]  moves_ext;
    logic [CMP_W-1:0]  tap_full;
    logic [IDX_W-1:0]  tap_idx;
    stamp_t            cell_q [MAX_WINDOW];
    stamp_t            tap_q  [MAX_WINDOW];
    stamp_t            oldest;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    stamp_t            sum_reg;
    stamp_t            sum_next;
    stamp_t            sum_add;
    stamp_t            best_reg;
    stamp_t            best_next;
    logic              slide;
    logic              out_valid_reg;
    stamp_t            best_free_time_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_end_reg <= '0;
            moves_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EVENT_END:     event_end_reg <= cfg_data;
                CFG_MOVES_ALLOWED: moves_reg     <= cfg_data[MOVES_W-1:0];
                default:           ;
            endcase
        end
    end

    // front stage
    mfgw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .meeting_start (meeting_start),
        .meeting_end   (meeting_end),
        .last_meeting  (last_meeting),
        .event_end     (event_end_reg),
        .take          (take),
        .word_valid    (word_valid),
        .word          (word)
    );

    // push sequencing: the last word pushes its two gaps, leading gap first, then closing gap
    assign out_free = !out_valid_reg || !out_stall;
    assign push     = word_valid && (!phase_reg || out_free);
    assign emit     = push && phase_reg;
    assign take     = word_valid && (word.last ? (phase_reg && out_free) : 1'b1);
    assign gap_sel  = phase_reg ? word.gap_final : word.gap_first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else if (push)
        begin
            phase_reg <= word.last && !phase_reg;
        end
    end

    // tap position: window length minus one, capped by the row length
    assign moves_ext = CMP_W'(moves_reg);
    assign tap_full  = (moves_ext > CMP_W'(MAX_WINDOW - 1)) ? CMP_W'(MAX_WINDOW - 1)
                                                              : moves_ext;
    assign tap_idx   = tap_full[IDX_W-1:0];

    // row of gap cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            stamp_t cell_in;
            if (gi == 0)
            begin : g_head
                assign cell_in = gap_sel;
            end
            else
            begin : g_link
                assign cell_in = cell_q[gi-1];
            end
            mfgw_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk      (clk),
                .push     (push),
                .data_in  (cell_in),
                .tap_idx  (tap_idx),
                .data_out (cell_q[gi]),
                .tap_out  (tap_q[gi])
            );
        end
    endgenerate

    // leaving gap: per-bit or over the masked taps
    genvar bi, ci;
    generate
        for (bi = 0; bi < STAMP_W; bi++)
        begin : g_bit
            logic [MAX_WINDOW-1:0] column;
            for (ci = 0; ci < MAX_WINDOW; ci++)
            begin : g_col
                assign column[ci] = tap_q[ci][bi];
            end
            assign oldest[bi] = |column;
        end
    endgenerate

    // window sum and running best
    always_comb
    begin
        slide   = seen_reg > SEEN_W'(tap_idx);
        sum_add = sum_reg + gap_sel;
        if (slide)
        begin
            sum_next  = sum_add - oldest;
            best_next = (sum_next > best_reg) ? sum_next : best_reg;
        end
        else
        begin
            sum_next  = sum_add;
            best_next = sum_add;
        end
        seen_next = (seen_reg == SEEN_W'(MAX_WINDOW)) ? seen_reg : seen_reg + SEEN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            sum_reg  <= '0;
            best_reg <= '0;
        end
        else if (emit)
        begin
            seen_reg <= '0;
            sum_reg  <= '0;
            best_reg <= '0;
        end
        else if (push)
        begin
            seen_reg <= seen_next;
            sum_reg  <= sum_next;
            best_reg <= best_next;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            best_free_time_reg <= best_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign best_free_time = best_free_time_reg;

    // checks
    `MFGW_ASSERT_NOW(a_phase_only_on_last, phase_reg, word_valid && word.last)
    `MFGW_ASSERT_NEXT(a_emit_fills_output, emit, out_valid_reg)
    `MFGW_ASSERT_NEXT(a_emit_clears_stream, emit, (seen_reg == '0) && (sum_reg == '0))
    `MFGW_ASSERT_NOW(a_seen_saturates, 1'b1, seen_reg <= SEEN_W'(MAX_WINDOW))

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for max_free_gap_window
// ----------------------------------------------------------------------------
// Feeds meeting words through the valid/stall input channel and checks every
// best_free_time word against a predictor of the gap ring and window sum.
// A directed part covers window lengths at the extremes, overlapping times,
// a clamped final gap, sums that wrap, and a window change inside a stream.
// The random part is mostly ordered meeting streams of random length, plus
// noise phases with raw 32-bit times. Both channels idle and stall at random.
// Configuration changes only while the block is drained.
// ----------------------------------------------------------------------------

// predictor of the gap window and store of the best sums still due
class free_time_board;

    localparam int RING_DEPTH = 64;

    mfgw_pkg::stamp_t event_end;
    mfgw_pkg::moves_t moves;
    mfgw_pkg::stamp_t prev_end;
    mfgw_pkg::stamp_t ring [RING_DEPTH];
    int unsigned      ring_ptr;
    int unsigned      gaps_seen;
    mfgw_pkg::stamp_t window_sum;
    mfgw_pkg::stamp_t best_sum;
    mfgw_pkg::stamp_t best_due [$];
    int               errors;
    int               checked;

    function new();
        event_end  = '0;
        moves      = '0;
        errors     = 0;
        checked    = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        prev_end   = '0;
        ring_ptr   = 0;
        gaps_seen  = 0;
        window_sum = '0;
        best_sum   = '0;
    endfunction

    function void set_reg(mfgw_pkg::cfg_idx_t idx, mfgw_pkg::stamp_t data);
        if (idx == mfgw_pkg::CFG_EVENT_END)
            event_end = data;
        else if (idx == mfgw_pkg::CFG_MOVES_ALLOWED)
            moves = data[mfgw_pkg::MOVES_W-1:0];
    endfunction

    function mfgw_pkg::stamp_t clamped(mfgw_pkg::stamp_t from, mfgw_pkg::stamp_t to);
        return (to >= from) ? to - from : '0;
    endfunction

    // add one gap to the window, sliding out the oldest once it is full
    function void slide_in_gap(mfgw_pkg::stamp_t gap);
        int unsigned win;
        int unsigned old_idx;
        win = moves + 1;
        if (win > RING_DEPTH)
            win = RING_DEPTH;
        if (gaps_seen >= win)
        begin
            old_idx    = (ring_ptr + RING_DEPTH - win) % RING_DEPTH;
            window_sum = window_sum + gap - ring[old_idx];
            if (window_sum > best_sum)
                best_sum = window_sum;
        end
        else
        begin
            window_sum = window_sum + gap;
            best_sum   = window_sum;
        end
        ring[ring_ptr] = gap;
        ring_ptr       = (ring_ptr + 1) % RING_DEPTH;
        if (gaps_seen < RING_DEPTH)
            gaps_seen++;
    endfunction

    function void note_meeting(mfgw_pkg::stamp_t start, mfgw_pkg::stamp_t stop, bit last);
        if (gaps_seen == 0)
            slide_in_gap(start);
        else
            slide_in_gap(clamped(prev_end, start));
        prev_end = stop;
        if (last)
        begin
            slide_in_gap(clamped(stop, event_end));
            best_due = {best_due, best_sum};
            clear_stream();
        end
    endfunction

    function void check_best(mfgw_pkg::stamp_t actual);
        mfgw_pkg::stamp_t want;
        checked++;
        if (best_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected best_free_time word %0d", $time, actual);
        end
        else
        begin
            want = best_due.pop_front();
            if (actual !== want)
            begin
                errors++;
                $display("%0t: best_free_time mismatch, expected %0d, actual %0d",
                         $time, want, actual);
            end
        end
    endfunction

    function int outstanding();
        return best_due.size();
    endfunction

endclass

module testbench;

    import mfgw_pkg::*;

    localparam int RANDOM_MEETINGS = 500;
    localparam int CYCLE_LIMIT     = 400000;

    logic     clk            = 1'b0;
    logic     rst_n          = 1'b0;
    logic     cfg_we         = 1'b0;
    cfg_idx_t cfg_index      = '0;
    stamp_t   cfg_data       = '0;
    logic     in_valid       = 1'b0;
    logic     in_stall;
    stamp_t   meeting_start  = '0;
    stamp_t   meeting_end    = '0;
    logic     last_meeting   = 1'b0;
    logic     out_valid;
    logic     out_stall      = 1'b0;
    stamp_t   best_free_time;

    free_time_board board;
    bit             rush;
    int             meetings_sent;
    int             phases;
    int             stall_left;
    int             cycles;

    max_free_gap_window u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .meeting_start  (meeting_start),
        .meeting_end    (meeting_end),
        .last_meeting   (last_meeting),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_free_time (best_free_time)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check each accepted word, then stall for a random while
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_best(best_free_time);
                stall_left = rush ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // register write, one cycle with the enable high
    task write_reg(cfg_idx_t idx, stamp_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // offer one meeting word after a random gap and wait until it is taken
    task offer_meeting(stamp_t start, stamp_t stop, bit last);
        int idle;
        idle = rush ? 0 : $urandom_range(0, 9);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid      <= 1'b1;
        meeting_start <= start;
        meeting_end   <= stop;
        last_meeting  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_meeting(start, stop, last);
        meetings_sent++;
    endtask

    // hold off the sender until every best sum has come back
    task drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int          pick;
        int          streams;
        int          len;
        int          random_start;
        bit          noise;
        bit          broken;
        int unsigned t;
        stamp_t      s;
        stamp_t      e;

        board         = new();
        rush          = 1'b0;
        meetings_sent = 0;
        phases        = 0;
        stall_left    = 0;
        cycles        = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of one gap, overlapping times, final gap past event_end
        write_reg(CFG_EVENT_END, 32'd100);
        write_reg(CFG_MOVES_ALLOWED, 32'd0);
        offer_meeting(32'd10, 32'd20, 1'b1);
        offer_meeting(32'd50, 32'd40, 1'b0);
        offer_meeting(32'd30, 32'd60, 1'b1);
        offer_meeting(32'd5, 32'd200, 1'b1);

        // widest window, fewer gaps than its length
        drain_results();
        write_reg(CFG_MOVES_ALLOWED, 32'd63);
        offer_meeting(32'd1, 32'd2, 1'b0);
        offer_meeting(32'd4, 32'd8, 1'b0);
        offer_meeting(32'd9, 32'd10, 1'b1);

        // extreme times, sums that wrap
        drain_results();
        write_reg(CFG_EVENT_END, 32'hFFFF_FFFF);
        offer_meeting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        offer_meeting(32'd0, 32'd0, 1'b0);
        offer_meeting(32'hFFFF_FFFF, 32'd0, 1'b1);
        offer_meeting(32'h8000_0000, 32'h8000_0000, 1'b1);

        // window length changed inside a stream, event_end of zero
        drain_results();
        write_reg(CFG_MOVES_ALLOWED, 32'd1);
        write_reg(CFG_EVENT_END, 32'd0);
        offer_meeting(32'd3, 32'd7, 1'b0);
        offer_meeting(32'd12, 32'd20, 1'b0);
        drain_results();
        write_reg(CFG_MOVES_ALLOWED, 32'd2);
        offer_meeting(32'd25, 32'd30, 1'b0);
        offer_meeting(32'd31, 32'd40, 1'b1);
        drain_results();
        write_reg(CFG_MOVES_ALLOWED, 32'd0);
        offer_meeting(32'd45, 32'd50, 1'b0);
        offer_meeting(32'd70, 32'd80, 1'b1);

        // random phases: mostly ordered streams, some raw noise
        random_start = meetings_sent;
        while (meetings_sent - random_start < RANDOM_MEETINGS)
        begin
            drain_results();
            phases++;
            rush  = ($urandom_range(0, 3) == 0);
            noise = ($urandom_range(0, 4) == 0);
            pick  = $urandom_range(0, 3);
            if (pick != 1)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(CFG_MOVES_ALLOWED, 32'd0);
                    1:       write_reg(CFG_MOVES_ALLOWED, 32'd63);
                    2:       write_reg(CFG_MOVES_ALLOWED, $urandom_range(0, 63));
                    default: write_reg(CFG_MOVES_ALLOWED, $urandom_range(1, 7));
                endcase
            end
            if (pick != 2)
                write_reg(CFG_EVENT_END, noise ? $urandom() : $urandom_range(200000, 400000));

            if (noise)
            begin
                repeat ($urandom_range(3, 12))
                    offer_meeting($urandom(), $urandom(), $urandom_range(0, 3) == 0);
            end
            else
            begin
                streams = $urandom_range(1, 3);
                for (int n = 0; n < streams; n++)
                begin
                    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                         : $urandom_range(1, 12);
                    broken = (n == streams - 1) && ($urandom_range(0, 6) == 0);
                    t      = $urandom_range(0, 1000);
                    for (int k = 0; k < len; k++)
                    begin
                        s = t + $urandom_range(0, 500);
                        e = s + $urandom_range(0, 300);
                        offer_meeting(s, e, (k == len - 1) && !broken);
                        t = e;
                    end
                end
            end
        end

        rush = 1'b0;
        drain_results();
        repeat (10) @(posedge clk);

        $display("covered %0d meetings over %0d random phases, %0d best sums checked",
                 meetings_sent, phases, board.checked);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
